### rtl/core/tcb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcb_pkg;

    // Default screen geometry in character cells
    localparam int COLS_DEF = 64;
    localparam int ROWS_DEF = 32;

    // Action codes
    typedef logic [1:0] action_t;
    localparam action_t ACT_PUT   = 2'd0;
    localparam action_t ACT_CLEAR = 2'd1;
    localparam action_t ACT_READ  = 2'd2;

    // Nibble mask to split a glyph code into font sheet tile coordinates
    localparam logic [7:0] NIBBLE_MASK = 8'h0F;

    // Attribute word kept per cell: colors and depth
    typedef struct packed {
        logic [7:0] fg;
        logic [7:0] bg;
        logic [7:0] depth;
    } attr_t;

endpackage

`default_nettype wire

### rtl/core/text_cell_buffer_depth_test.sv
`timescale 1ns / 1ps
`default_nettype none

// Character-cell screen buffer with a per-cell depth test. Each of the
// COLS x ROWS cells holds a glyph code in one memory and its foreground,
// background and depth in a second one; both are synchronous memories with
// a registered read port. When a put or read transaction is taken, the
// addressed cell is read; in state S_LOOK, once the output register is free,
// the depth test runs, the cell is written back and the result is loaded
// into the output register. The block takes no new put or read until this
// single read-modify-write pass over the cell memories is done; only one
// transaction is in flight at a time, so a write never races a read of the
// same cell. A clear transaction sweeps the attribute memory one cell a
// cycle; glyphs are kept. After reset the block runs a clearing pass over
// both memories with in_ready low. The output register lets the next
// transaction be accepted while a result is still waiting on out_ready.
// Off-screen coordinates (negative, or at or beyond COLS / ROWS) on a put or
// read never write a cell and report on_screen low.

module text_cell_buffer_depth_test #(
    parameter int COLS = tcb_pkg::COLS_DEF,
    parameter int ROWS = tcb_pkg::ROWS_DEF
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_ready,
    input  wire tcb_pkg::action_t action,
    input  wire  signed [7:0]  col,
    input  wire  signed [7:0]  row,
    input  wire         [7:0]  glyph_code,
    input  wire         [7:0]  fg_color,
    input  wire         [7:0]  bg_color,
    input  wire         [7:0]  depth,
    input  wire                ignore_depth,
    output logic               out_valid,
    input  wire                out_ready,
    output logic               written,
    output logic        [3:0]  tile_col,
    output logic        [3:0]  tile_row,
    output logic        [7:0]  cell_fg,
    output logic        [7:0]  cell_bg,
    output logic               on_screen
);
    import tcb_pkg::*;

    localparam int CELLS  = COLS * ROWS;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
    localparam logic [7:0] COLS_W = 8'(COLS);
    localparam logic [7:0] ROWS_W = 8'(ROWS);

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_LOOK,
        S_CLEAR
    } state_t;

    // Cell memories
    logic [7:0] glyph_mem [CELLS];
    attr_t      attr_mem  [CELLS];
    logic [7:0] glyph_rd_reg;
    attr_t      attr_rd_reg;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] sweep_reg, sweep_next;

    // Latched transaction
    action_t           act_reg, act_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic              on_reg, on_next;
    logic [7:0]        glyph_reg, glyph_next;
    logic [7:0]        fg_reg, fg_next;
    logic [7:0]        bg_reg, bg_next;
    logic [7:0]        dep_reg, dep_next;
    logic              ign_reg, ign_next;

    // Output register
    logic       out_valid_reg, out_valid_next;
    logic       written_reg, written_next;
    logic [3:0] tile_col_reg, tile_col_next;
    logic [3:0] tile_row_reg, tile_row_next;
    logic [7:0] cell_fg_reg, cell_fg_next;
    logic [7:0] cell_bg_reg, cell_bg_next;
    logic       on_screen_reg, on_screen_next;

    // Memory ports
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              glyph_we;
    logic              attr_we;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        glyph_wd;
    attr_t             attr_wd;

    logic              in_fire;
    logic              out_free;
    logic              on_in;
    logic [13:0]       idx_full;
    logic [ADDR_W-1:0] idx_in;
    logic              pass;
    logic [7:0]        glyph_masked_lo;
    logic [7:0]        glyph_masked_hi;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Bounds check and cell address of the incoming transaction
    assign on_in = !col[7] && !row[7] && ($unsigned(col) < COLS_W)
                   && ($unsigned(row) < ROWS_W);
    assign idx_full = 14'(row[6:0]) * 14'(COLS) + 14'(col[6:0]);
    assign idx_in   = on_in ? ADDR_W'(idx_full) : '0;

    // Depth test: equal depth wins, bypassed when ignore_depth is set
    assign pass = on_reg && (ign_reg || (dep_reg >= attr_rd_reg.depth));

    assign glyph_masked_lo = glyph_rd_reg & NIBBLE_MASK;
    assign glyph_masked_hi = (glyph_rd_reg >> 4) & NIBBLE_MASK;

    always_comb
    begin
        state_next     = state_reg;
        sweep_next     = sweep_reg;
        act_next       = act_reg;
        idx_next       = idx_reg;
        on_next        = on_reg;
        glyph_next     = glyph_reg;
        fg_next        = fg_reg;
        bg_next        = bg_reg;
        dep_next       = dep_reg;
        ign_next       = ign_reg;
        out_valid_next = out_valid_reg && !out_ready;
        written_next   = written_reg;
        tile_col_next  = tile_col_reg;
        tile_row_next  = tile_row_reg;
        cell_fg_next   = cell_fg_reg;
        cell_bg_next   = cell_bg_reg;
        on_screen_next = on_screen_reg;

        rd_en    = 1'b0;
        rd_addr  = idx_in;
        glyph_we = 1'b0;
        attr_we  = 1'b0;
        wr_addr  = idx_reg;
        glyph_wd = glyph_reg;
        attr_wd  = '{fg: fg_reg, bg: bg_reg,
                     depth: ign_reg ? attr_rd_reg.depth : dep_reg};

        case (state_reg)
            S_INIT:
            begin
                // Zero both memories one cell a cycle
                glyph_we   = 1'b1;
                attr_we    = 1'b1;
                wr_addr    = sweep_reg;
                glyph_wd   = '0;
                attr_wd    = '0;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == LAST_CELL)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    rd_en      = 1'b1;
                    act_next   = action;
                    idx_next   = idx_in;
                    on_next    = on_in;
                    glyph_next = glyph_code;
                    fg_next    = fg_color;
                    bg_next    = bg_color;
                    dep_next   = depth;
                    ign_next   = ignore_depth;
                    sweep_next = '0;
                    state_next = (action == ACT_CLEAR) ? S_CLEAR : S_LOOK;
                end
            end
            S_CLEAR:
            begin
                // Zero colors and depth, keep glyphs
                attr_we    = 1'b1;
                wr_addr    = sweep_reg;
                attr_wd    = '0;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == LAST_CELL)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                // Hold until the output register frees up
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    written_next   = 1'b0;
                    tile_col_next  = '0;
                    tile_row_next  = '0;
                    cell_fg_next   = '0;
                    cell_bg_next   = '0;
                    on_screen_next = 1'b0;
                    case (act_reg)
                        ACT_PUT:
                        begin
                            on_screen_next = on_reg;
                            written_next   = pass;
                            glyph_we       = pass;
                            attr_we        = pass;
                        end
                        ACT_READ:
                        begin
                            on_screen_next = on_reg;
                            if (on_reg)
                            begin
                                tile_col_next = glyph_masked_lo[3:0];
                                tile_row_next = glyph_masked_hi[3:0];
                                cell_fg_next  = attr_rd_reg.fg;
                                cell_bg_next  = attr_rd_reg.bg;
                            end
                        end
                        default:
                        begin
                            // Clear and the unused code report all zero
                        end
                    endcase
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            sweep_reg     <= '0;
            act_reg       <= ACT_PUT;
            idx_reg       <= '0;
            on_reg        <= 1'b0;
            glyph_reg     <= '0;
            fg_reg        <= '0;
            bg_reg        <= '0;
            dep_reg       <= '0;
            ign_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            written_reg   <= 1'b0;
            tile_col_reg  <= '0;
            tile_row_reg  <= '0;
            cell_fg_reg   <= '0;
            cell_bg_reg   <= '0;
            on_screen_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            act_reg       <= act_next;
            idx_reg       <= idx_next;
            on_reg        <= on_next;
            glyph_reg     <= glyph_next;
            fg_reg        <= fg_next;
            bg_reg        <= bg_next;
            dep_reg       <= dep_next;
            ign_reg       <= ign_next;
            out_valid_reg <= out_valid_next;
            written_reg   <= written_next;
            tile_col_reg  <= tile_col_next;
            tile_row_reg  <= tile_row_next;
            cell_fg_reg   <= cell_fg_next;
            cell_bg_reg   <= cell_bg_next;
            on_screen_reg <= on_screen_next;
        end
    end

    // Glyph memory
    always_ff @(posedge clk)
    begin
        if (glyph_we)
        begin
            glyph_mem[wr_addr] <= glyph_wd;
        end
        if (rd_en)
        begin
            glyph_rd_reg <= glyph_mem[rd_addr];
        end
    end

    // Attribute memory
    always_ff @(posedge clk)
    begin
        if (attr_we)
        begin
            attr_mem[wr_addr] <= attr_wd;
        end
        if (rd_en)
        begin
            attr_rd_reg <= attr_mem[rd_addr];
        end
    end

    assign out_valid = out_valid_reg;
    assign written   = written_reg;
    assign tile_col  = tile_col_reg;
    assign tile_row  = tile_row_reg;
    assign cell_fg   = cell_fg_reg;
    assign cell_bg   = cell_bg_reg;
    assign on_screen = on_screen_reg;

endmodule

`default_nettype wire

### rtl/core/tcb_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module tcb_checker (
    input wire       clk,
    input wire       rst_n,
    input wire       out_valid,
    input wire       out_ready,
    input wire       written,
    input wire [3:0] tile_col,
    input wire [3:0] tile_row,
    input wire [7:0] cell_fg,
    input wire [7:0] cell_bg,
    input wire       on_screen
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(written)
            && $stable(tile_col) && $stable(tile_row) && $stable(cell_fg)
            && $stable(cell_bg) && $stable(on_screen))
        else $error("result changed while stalled");

    // A write only lands on screen
    a_written_on: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && written |-> on_screen)
        else $error("write reported off screen");

    // A written put result carries no cell contents
    a_put_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && written |-> tile_col == 4'd0 && tile_row == 4'd0
            && cell_fg == 8'd0 && cell_bg == 8'd0)
        else $error("put result carries cell contents");

    // Off screen results report zero contents
    a_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !on_screen |-> tile_col == 4'd0 && tile_row == 4'd0
            && cell_fg == 8'd0 && cell_bg == 8'd0)
        else $error("off screen result carries cell contents");

endmodule

bind text_cell_buffer_depth_test tcb_checker u_tcb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .written   (written),
    .tile_col  (tile_col),
    .tile_row  (tile_row),
    .cell_fg   (cell_fg),
    .cell_bg   (cell_bg),
    .on_screen (on_screen)
);

`default_nettype wire
